FILE: hw/rtl/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg: shared types for the first-fit span allocator
// Holds the controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package ffsa_pkg;

  localparam int unsigned TotalBits = 48;

  typedef struct packed {
    logic start_req;   // latch request, compute rounded size
    logic rd_span;     // issue span memory read at walk index
    logic chk_alloc;   // evaluate alloc candidate from read data
    logic chk_merge;   // evaluate merge candidate
    logic chk_empty;   // evaluate empty slot candidate
    logic do_take;     // write shrunk span
    logic do_open;     // open new block
    logic do_merge;    // write merged span
    logic do_insert;   // write new span
    logic clr_used;    // clear used bit at walk index (set it at slot 0)
    logic step;        // advance walk index
    logic rst_idx;     // zero walk index
    logic finish;      // build result
    logic [1:0] fin_status;
  } ffsa_cmd_t;

  typedef struct packed {
    logic is_free;
    logic bad_type;
    logic bad_block;
    logic hit;         // candidate check found a match
    logic idx_last;    // walk index at last slot
    logic blk_skip;    // current block not eligible for alloc
    logic have_slot;   // a closed block slot exists
  } ffsa_sts_t;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoBlock = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;

endpackage

FILE: hw/rtl/ffsa_ctrl.sv
// ----------------------------------------------------------------------------
// ffsa_ctrl: request sequencer
// Walks the span memory one slot per step for the alloc, merge and insert
// searches and issues datapath commands.
// ----------------------------------------------------------------------------
module ffsa_ctrl
  import ffsa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  ffsa_sts_t sts_i,
  output ffsa_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_ARD, S_ACHK, S_OPEN, S_MRD, S_MCHK, S_ERD, S_ECHK,
    S_CLR, S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign out_valid_o = out_valid_q;
  assign in_stall_o  = (state_q != S_IDLE) || out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && !out_valid_q) begin
          cmd_o.start_req = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.rst_idx = 1'b1;
        if (sts_i.bad_type) begin
          cmd_o.finish = 1'b1;
          cmd_o.fin_status = sts_i.is_free ? StOk : StNoBlock;
          state_d = S_OUT;
        end else if (sts_i.is_free) begin
          if (sts_i.bad_block) begin
            cmd_o.finish = 1'b1;
            cmd_o.fin_status = StOk;
            state_d = S_OUT;
          end else begin
            state_d = S_MRD;
          end
        end else begin
          state_d = S_ARD;
        end
      end
      S_ARD: begin
        if (sts_i.blk_skip) begin
          if (sts_i.idx_last) begin
            state_d = S_OPEN;
          end else begin
            cmd_o.step = 1'b1;
          end
        end else begin
          cmd_o.rd_span = 1'b1;
          state_d = S_ACHK;
        end
      end
      S_ACHK: begin
        cmd_o.chk_alloc = 1'b1;
        if (sts_i.hit) begin
          cmd_o.do_take = 1'b1;
          cmd_o.finish = 1'b1;
          cmd_o.fin_status = StOk;
          state_d = S_OUT;
        end else if (sts_i.idx_last) begin
          state_d = S_OPEN;
        end else begin
          cmd_o.step = 1'b1;
          state_d = S_ARD;
        end
      end
      S_OPEN: begin
        cmd_o.rst_idx = 1'b1;
        if (sts_i.have_slot) begin
          cmd_o.do_open = 1'b1;
          state_d = S_CLR;
        end else begin
          cmd_o.finish = 1'b1;
          cmd_o.fin_status = StNoBlock;
          state_d = S_OUT;
        end
      end
      S_CLR: begin
        cmd_o.clr_used = 1'b1;
        if (sts_i.idx_last) begin
          cmd_o.finish = 1'b1;
          cmd_o.fin_status = StOk;
          state_d = S_OUT;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_MRD: begin
        cmd_o.rd_span = 1'b1;
        state_d = S_MCHK;
      end
      S_MCHK: begin
        cmd_o.chk_merge = 1'b1;
        if (sts_i.hit) begin
          cmd_o.do_merge = 1'b1;
          cmd_o.finish = 1'b1;
          cmd_o.fin_status = StOk;
          state_d = S_OUT;
        end else if (sts_i.idx_last) begin
          cmd_o.rst_idx = 1'b1;
          state_d = S_ERD;
        end else begin
          cmd_o.step = 1'b1;
          state_d = S_MRD;
        end
      end
      S_ERD: begin
        state_d = S_ECHK;
      end
      S_ECHK: begin
        cmd_o.chk_empty = 1'b1;
        if (sts_i.hit) begin
          cmd_o.do_insert = 1'b1;
          cmd_o.finish = 1'b1;
          cmd_o.fin_status = StOk;
          state_d = S_OUT;
        end else if (sts_i.idx_last) begin
          cmd_o.finish = 1'b1;
          cmd_o.fin_status = StFull;
          state_d = S_OUT;
        end else begin
          cmd_o.step = 1'b1;
          state_d = S_ERD;
        end
      end
      S_OUT: begin
        out_valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: hw/rtl/ffsa_dp.sv
// ----------------------------------------------------------------------------
// ffsa_dp: allocator datapath
// Span memory, block flags, type totals, request registers and result.
// ----------------------------------------------------------------------------
module ffsa_dp
  import ffsa_pkg::*;
#(
  parameter int unsigned MemTypes      = 4,
  parameter int unsigned BlocksPerType = 8,
  parameter int unsigned SpansPerBlock = 16,
  parameter int unsigned AddrBits      = 40
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [4:0]            page_shift_i,
  input  logic [10:0]           min_block_pages_i,
  input  logic                  action_i,
  input  logic [1:0]            mem_type_i,
  input  logic [39:0]           req_size_i,
  input  logic                  own_page_i,
  input  logic [39:0]           req_offset_i,
  input  logic [2:0]            req_block_i,
  input  ffsa_cmd_t             cmd_i,
  output ffsa_sts_t             sts_o,
  output logic [1:0]            status_o,
  output logic [39:0]           alloc_offset_o,
  output logic [2:0]            alloc_block_o,
  output logic                  opened_block_o,
  output logic [39:0]           opened_size_o,
  output logic [TotalBits-1:0]  type_bytes_o
);

  localparam int unsigned TW  = (MemTypes > 1) ? $clog2(MemTypes) : 1;
  localparam int unsigned BW  = (BlocksPerType > 1) ? $clog2(BlocksPerType) : 1;
  localparam int unsigned SW  = $clog2(SpansPerBlock);
  localparam int unsigned NBlk = MemTypes * BlocksPerType;
  localparam int unsigned NSpan = NBlk * SpansPerBlock;
  localparam int unsigned BIW = $clog2(NBlk) > 0 ? $clog2(NBlk) : 1;
  localparam int unsigned SIW = $clog2(NSpan);
  localparam int unsigned IW  = (BW > SW ? BW : SW) + 1;
  localparam logic [AddrBits-1:0] AddrMax = '1;
  localparam logic [TotalBits-1:0] TotMax = '1;

  // Request registers.
  logic                is_free_q, own_q;
  logic [1:0]          type_q;
  logic [AddrBits-1:0] r_q, off_q, blk_size_q;
  logic [2:0]          rblk_q;
  logic [BW-1:0]       blk_q;   // block being walked or chosen
  logic [SW-1:0]       span_q;
  logic [IW-1:0]       idx_q;
  logic                req_ok_q;

  // Storage.
  logic [AddrBits-1:0] start_mem [NSpan];
  logic [AddrBits-1:0] len_mem   [NSpan];
  logic                used_mem  [NSpan];
  logic [NBlk-1:0]     open_q, resv_q;
  logic [TotalBits-1:0] total_q [MemTypes];
  logic [5:0]          opened_cnt_q;
  logic [AddrBits-1:0] rd_start_q, rd_len_q;
  logic                rd_used_q;

  // Rounding.
  logic [AddrBits:0] page_m1, sum_w, rnd_w;
  logic [AddrBits-1:0] size_a, r_d;
  always_comb begin
    size_a  = req_size_i[AddrBits-1:0];
    page_m1 = ((AddrBits+1)'(1) << page_shift_i) - (AddrBits+1)'(1);
    sum_w   = {1'b0, size_a} + page_m1;
    rnd_w   = sum_w & ~page_m1;
    r_d     = rnd_w[AddrBits] ? AddrMax : rnd_w[AddrBits-1:0];
  end

  logic [TW-1:0] t;
  assign t = type_q[TW-1:0];

  // Walk address.
  logic [BIW-1:0] cur_bi;
  logic [SIW-1:0] cur_si;
  logic [BW-1:0]  walk_b;
  logic [SW-1:0]  walk_s;
  always_comb begin
    if (is_free_q) begin
      walk_b = rblk_q[BW-1:0];
      walk_s = idx_q[SW-1:0];
    end else begin
      walk_b = blk_q;
      walk_s = span_q;
    end
    cur_bi = BIW'(t * BlocksPerType + walk_b);
    cur_si = SIW'(cur_bi * SpansPerBlock + walk_s);
  end

  // Lowest closed block slot.
  logic           have_slot;
  logic [BW-1:0]  slot_b;
  always_comb begin
    have_slot = 1'b0;
    slot_b    = '0;
    for (int i = BlocksPerType - 1; i >= 0; i--) begin
      if (!open_q[t * BlocksPerType + i]) begin
        have_slot = 1'b1;
        slot_b    = BW'(i);
      end
    end
  end

  logic [AddrBits-1:0] end_a;
  assign end_a = off_q + r_q;

  logic hit;
  always_comb begin
    hit = 1'b0;
    if (cmd_i.chk_alloc) begin
      hit = rd_used_q && !(own_q && rd_start_q != '0) && rd_len_q >= r_q;
    end else if (cmd_i.chk_merge) begin
      hit = rd_used_q && rd_start_q == end_a;
    end else if (cmd_i.chk_empty) begin
      hit = !rd_used_q;
    end
  end

  logic last_alloc;
  assign last_alloc = (blk_q == BW'(BlocksPerType - 1)) && (span_q == SW'(SpansPerBlock - 1));

  always_comb begin
    sts_o.is_free   = is_free_q;
    sts_o.bad_type  = !req_ok_q;
    sts_o.bad_block = (32'(rblk_q) >= BlocksPerType) ||
                      !open_q[BIW'(t * BlocksPerType + rblk_q[BW-1:0])];
    sts_o.hit       = hit;
    sts_o.blk_skip  = !open_q[cur_bi] || resv_q[cur_bi];
    sts_o.have_slot = have_slot;
    if (is_free_q) begin
      sts_o.idx_last = idx_q[SW-1:0] == SW'(SpansPerBlock - 1);
    end else if (cmd_i.chk_alloc) begin
      sts_o.idx_last = last_alloc;
    end else begin
      // skip a whole block at once
      sts_o.idx_last = blk_q == BW'(BlocksPerType - 1);
    end
    if (cmd_i.clr_used) begin
      sts_o.idx_last = idx_q[SW-1:0] == SW'(SpansPerBlock - 1);
    end
  end

  // New block size.
  logic [AddrBits:0]   dbl;
  logic [AddrBits+26:0] minsz_w;
  logic [AddrBits-1:0] bsize, minsz;
  always_comb begin
    dbl     = {1'b0, r_q} + {1'b0, r_q};
    minsz_w = (AddrBits+27)'(min_block_pages_i) << page_shift_i;
    minsz   = (minsz_w > (AddrBits+27)'(AddrMax)) ? AddrMax : minsz_w[AddrBits-1:0];
    bsize   = dbl[AddrBits] ? AddrMax : dbl[AddrBits-1:0];
    if (bsize < minsz) bsize = minsz;
  end

  logic [AddrBits:0]    mlen;
  logic [TotalBits:0]   tadd;
  logic [TotalBits-1:0] tadd_s, tsub, r_tot;
  always_comb begin
    mlen   = {1'b0, rd_len_q} + {1'b0, r_q};
    r_tot  = TotalBits'(r_q);
    tadd   = {1'b0, total_q[t]} + {1'b0, r_tot};
    tadd_s = tadd[TotalBits] ? TotMax : tadd[TotalBits-1:0];
    tsub   = (total_q[t] > r_tot) ? total_q[t] - r_tot : '0;
  end

  // Span memory: one write and one registered read port.
  logic                wr_en;
  logic [SIW-1:0]      wr_a;
  logic [AddrBits-1:0] wr_st, wr_ln;
  always_comb begin
    wr_en = 1'b0;
    wr_a  = cur_si;
    wr_st = '0;
    wr_ln = '0;
    if (cmd_i.do_take) begin
      wr_en = 1'b1;
      wr_st = rd_start_q + r_q;
      wr_ln = rd_len_q - r_q;
    end else if (cmd_i.do_merge) begin
      wr_en = 1'b1;
      wr_st = off_q;
      wr_ln = mlen[AddrBits] ? AddrMax : mlen[AddrBits-1:0];
    end else if (cmd_i.do_insert) begin
      wr_en = 1'b1;
      wr_st = off_q;
      wr_ln = r_q;
    end else if (cmd_i.do_open) begin
      wr_en = 1'b1;
      wr_a  = SIW'((t * BlocksPerType + slot_b) * SpansPerBlock);
      wr_st = r_q;
      wr_ln = bsize - r_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      start_mem[wr_a] <= wr_st;
      len_mem[wr_a]   <= wr_ln;
    end
    rd_start_q <= start_mem[cur_si];
    rd_len_q   <= len_mem[cur_si];
  end

  // Payload request registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_req) begin
      is_free_q <= action_i;
      type_q    <= mem_type_i;
      own_q     <= own_page_i;
      r_q       <= r_d;
      off_q     <= req_offset_i[AddrBits-1:0];
      rblk_q    <= req_block_i;
      req_ok_q  <= 32'(mem_type_i) < MemTypes;
    end
    if (cmd_i.do_open) begin
      blk_size_q <= bsize;
    end
  end

  // Walk counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      blk_q  <= '0;
      span_q <= '0;
    end else if (cmd_i.rst_idx) begin
      idx_q  <= '0;
      span_q <= '0;
      if (!cmd_i.do_open) blk_q <= '0;
      else blk_q <= slot_b;
    end else if (cmd_i.step) begin
      if (is_free_q || cmd_i.clr_used) begin
        idx_q <= idx_q + IW'(1);
      end else if (!cmd_i.chk_alloc || span_q == SW'(SpansPerBlock - 1)) begin
        blk_q  <= blk_q + BW'(1);
        span_q <= '0;
      end else begin
        span_q <= span_q + SW'(1);
      end
    end
  end

  // Flags, totals, result.
  logic [SIW-1:0] clr_a;
  assign clr_a = SIW'(cur_bi * SpansPerBlock + idx_q[SW-1:0]);

  // Span used bits sit in a memory of their own. Only open blocks are ever
  // searched, and opening a block clears its slots first.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_used) begin
      used_mem[clr_a] <= (idx_q[SW-1:0] == '0);
    end else if (cmd_i.do_insert) begin
      used_mem[cur_si] <= 1'b1;
    end
    rd_used_q <= used_mem[cur_si];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q       <= '0;
      resv_q       <= '0;
      opened_cnt_q <= '0;
      for (int i = 0; i < MemTypes; i++) total_q[i] <= '0;
      status_o       <= '0;
      alloc_offset_o <= '0;
      alloc_block_o  <= '0;
      opened_block_o <= 1'b0;
      opened_size_o  <= '0;
      type_bytes_o   <= '0;
    end else begin
      if (cmd_i.do_take) begin
        resv_q[cur_bi] <= own_q;
        total_q[t]     <= tadd_s;
      end
      if (cmd_i.do_open) begin
        open_q[BIW'(t * BlocksPerType + slot_b)] <= 1'b1;
        resv_q[BIW'(t * BlocksPerType + slot_b)] <= own_q;
        opened_cnt_q <= opened_cnt_q + 6'd1;
        total_q[t]   <= tadd_s;
      end
      if (cmd_i.do_merge || cmd_i.do_insert) begin
        resv_q[cur_bi] <= 1'b0;
        total_q[t]     <= tsub;
      end
      if (cmd_i.finish) begin
        status_o       <= cmd_i.fin_status;
        alloc_offset_o <= '0;
        alloc_block_o  <= '0;
        opened_block_o <= 1'b0;
        opened_size_o  <= '0;
        if (!req_ok_q) type_bytes_o <= '0;
        else if (cmd_i.do_take) type_bytes_o <= tadd_s;
        else if (cmd_i.do_merge || cmd_i.do_insert) type_bytes_o <= tsub;
        else type_bytes_o <= total_q[t];
        if (cmd_i.do_take) begin
          alloc_offset_o <= 40'(rd_start_q);
          alloc_block_o  <= 3'(blk_q);
        end
        if (cmd_i.clr_used) begin
          alloc_block_o  <= 3'(blk_q);
          opened_block_o <= 1'b1;
          opened_size_o  <= 40'(blk_size_q);
        end
      end
    end
  end

endmodule

FILE: hw/rtl/first_fit_span_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_span_allocator_core: first-fit span allocator, top level
// Register port, request sequencer and allocator datapath.
// ----------------------------------------------------------------------------
// Usage: one request transfer enters on in_valid_i/in_stall_o with the
// fields action_i .. req_block_i, and exactly one result transfer leaves on
// out_valid_o/out_stall_i. Configuration (page_shift at 0x0, min_block_pages
// at 0x4) is written through the APB-style port while the block is idle.
// An allocation walks the spans of its memory type one slot at a time,
// reading and then checking each one, and skips a closed or reserved block
// in a single step; opening a new block when none fits also clears its span
// slots. A free walks one block at most twice, first for a merge and then
// for an empty slot. The span memory has a single registered read port.
// One request is worked on at a time. The result stays in an output
// register while the receiver stalls, and no new request is taken until it
// has left. Reset empties all pools, zeroes the totals and restores the
// register defaults; span contents are only read after being written.
// ----------------------------------------------------------------------------
module first_fit_span_allocator_core
  import ffsa_pkg::*;
#(
  parameter int unsigned MEM_TYPES       = 4,
  parameter int unsigned BLOCKS_PER_TYPE = 8,
  parameter int unsigned SPANS_PER_BLOCK = 16,
  parameter int unsigned ADDR_BITS       = 40
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [1:0]  mem_type_i,
  input  logic [39:0] req_size_i,
  input  logic        own_page_i,
  input  logic [39:0] req_offset_i,
  input  logic [2:0]  req_block_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [39:0] alloc_offset_o,
  output logic [2:0]  alloc_block_o,
  output logic        opened_block_o,
  output logic [39:0] opened_size_o,
  output logic [47:0] type_bytes_o
);

  localparam logic [2:0] AddrPageShift = 3'h0;
  localparam logic [2:0] AddrMinPages  = 3'h4;

  logic [4:0]  page_shift_q;
  logic [10:0] min_pages_q;

  assign pready = 1'b1;

  // Register write happens in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_shift_q <= 5'd8;
      min_pages_q  <= 11'd10;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        AddrPageShift: page_shift_q <= pwdata[4:0];
        AddrMinPages:  min_pages_q  <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      AddrPageShift: prdata = {27'd0, page_shift_q};
      AddrMinPages:  prdata = {21'd0, min_pages_q};
      default:       prdata = '0;
    endcase
  end

  ffsa_cmd_t cmd;
  ffsa_sts_t sts;

  ffsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffsa_dp #(
    .MemTypes     (MEM_TYPES),
    .BlocksPerType(BLOCKS_PER_TYPE),
    .SpansPerBlock(SPANS_PER_BLOCK),
    .AddrBits     (ADDR_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .page_shift_i     (page_shift_q),
    .min_block_pages_i(min_pages_q),
    .action_i         (action_i),
    .mem_type_i       (mem_type_i),
    .req_size_i       (req_size_i),
    .own_page_i       (own_page_i),
    .req_offset_i     (req_offset_i),
    .req_block_i      (req_block_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .status_o         (status_o),
    .alloc_offset_o   (alloc_offset_o),
    .alloc_block_o    (alloc_block_o),
    .opened_block_o   (opened_block_o),
    .opened_size_o    (opened_size_o),
    .type_bytes_o     (type_bytes_o)
  );

endmodule
